// ===== hdl/ctcfl_pkg.sv =====
package ctcfl_pkg;

    localparam int NUM_CLASSES_DEF = 256;
    localparam int MAX_TARGET_DEF  = 64;
    localparam int FRAC_BITS_DEF   = 12;

    localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_MAX = -32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_LABEL  = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_FINISH = 2'd3
    } req_t;

    // log(1+exp(-x)) at half steps, Q.12
    function automatic logic [11:0] lse_q12(input logic [3:0] idx);
        logic [11:0] v;
        begin
            case (idx)
                4'd0:  v = 12'd2839;
                4'd1:  v = 12'd1942;
                4'd2:  v = 12'd1283;
                4'd3:  v = 12'd825;
                4'd4:  v = 12'd520;
                4'd5:  v = 12'd323;
                4'd6:  v = 12'd199;
                4'd7:  v = 12'd122;
                4'd8:  v = 12'd74;
                4'd9:  v = 12'd45;
                4'd10: v = 12'd28;
                4'd11: v = 12'd17;
                4'd12: v = 12'd10;
                4'd13: v = 12'd6;
                4'd14: v = 12'd4;
                default: v = 12'd2;
            endcase
            return v;
        end
    endfunction

    // saturate a 34-bit sum to the finite range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sh0_7FFF_FFFF)
                r = POS_MAX;
            else if (v < -34'sh0_7FFF_FFFF)
                r = NEG_MAX;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ===== hdl/ctc_forward_loss.sv =====
// finish word: busy in FIN_RD, FIN_A, FIN_B and FIN_OUT, then a done strobe
// first step close: INIT_RD/P/WR for row[0], row[1] if L>0, then S_CLR up to 2L
// later step close: UPD_RD, LAB, P, A2, WR per alpha state over 2L+1 states
// throughput: start, label and open-step sample words one per cycle while not busy
// reset: asynchronous, rst_n low clears control; memories undefined until written
// results are single-cycle strobes on done and cannot be held off
module ctc_forward_loss #(
    parameter int NUM_CLASSES = ctcfl_pkg::NUM_CLASSES_DEF,
    parameter int MAX_TARGET  = ctcfl_pkg::MAX_TARGET_DEF,
    parameter int FRAC_BITS   = ctcfl_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [7:0]         label,
    input  logic signed [23:0] log_prob,
    input  logic               last_in_step,
    output logic               done,
    output logic [30:0]        loss,
    output logic               loss_infinite,
    output logic               target_overflow
);

    ctcfl_core #(
        .NUM_CLASSES(NUM_CLASSES),
        .MAX_TARGET(MAX_TARGET),
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .req_type(req_type), .label(label),
        .log_prob(log_prob), .last_in_step(last_in_step), .done(done),
        .loss(loss), .loss_infinite(loss_infinite),
        .target_overflow(target_overflow)
    );

endmodule

// ===== hdl/ctcfl_logadd.sv =====
// log-domain add of two values: max plus table correction
module ctcfl_logadd #(
    parameter int FRAC_BITS = ctcfl_pkg::FRAC_BITS_DEF
) (
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] y
);

    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic        [32:0] d;
    logic        [33:0] dr;
    logic        [33:0] idx;
    logic        [11:0] tv;
    logic signed [33:0] corr;

    always_comb
    begin
        hi  = (a > b) ? a : b;
        lo  = (a > b) ? b : a;
        d   = 33'({hi[31], hi} - {lo[31], lo});
        dr  = {1'b0, d} + (34'd1 << (FRAC_BITS - 2));
        idx = dr >> (FRAC_BITS - 1);
        tv  = ctcfl_pkg::lse_q12(idx[3:0]);
        if (FRAC_BITS >= 12)
            corr = $signed({22'd0, tv}) <<< (FRAC_BITS >= 12 ? FRAC_BITS - 12 : 0);
        else
            corr = $signed({22'd0, tv}) >>> (FRAC_BITS < 12 ? 12 - FRAC_BITS : 0);
        if (idx >= 34'd16)
            corr = '0;
        if (a == ctcfl_pkg::NEG_INF)
            y = b;
        else if (b == ctcfl_pkg::NEG_INF)
            y = a;
        else
            y = ctcfl_pkg::sat32({{2{hi[31]}}, hi} + corr);
    end

endmodule

// ===== hdl/ctcfl_core.sv =====
// sequencer around the probability, target and alpha memories
module ctcfl_core #(
    parameter int NUM_CLASSES = ctcfl_pkg::NUM_CLASSES_DEF,
    parameter int MAX_TARGET  = ctcfl_pkg::MAX_TARGET_DEF,
    parameter int FRAC_BITS   = ctcfl_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic [7:0]          label,
    input  logic signed [23:0]  log_prob,
    input  logic                last_in_step,
    output logic                done,
    output logic [30:0]         loss,
    output logic                loss_infinite,
    output logic                target_overflow
);

    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
    localparam int ROW_LEN = 2 * MAX_TARGET + 1;
    localparam int RW = $clog2(ROW_LEN);
    localparam int NW = $clog2(MAX_TARGET + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT_RD, S_INIT_P, S_INIT_WR, S_CLR,
        S_UPD_RD, S_UPD_LAB, S_UPD_P, S_UPD_A2, S_UPD_WR,
        S_FIN_RD, S_FIN_A, S_FIN_B, S_FIN_OUT
    } state_t;

    // memories
    logic signed [31:0] prob_mem [NUM_CLASSES];
    logic [7:0]         tgt_mem  [MAX_TARGET];
    logic signed [31:0] alpha_mem [ROW_LEN];

    logic signed [31:0] prob_rd;
    logic [7:0]         tgt_rd;
    logic signed [31:0] alpha_rd;

    logic               prob_we;
    logic [CW-1:0]      prob_wa;
    logic signed [31:0] prob_wd;
    logic [CW-1:0]      prob_ra;
    logic               tgt_we;
    logic [TW-1:0]      tgt_wa;
    logic [TW-1:0]      tgt_ra;
    logic               alpha_we;
    logic [RW-1:0]      alpha_wa;
    logic signed [31:0] alpha_wd;
    logic [RW-1:0]      alpha_ra;

    state_t             state_reg;
    logic [7:0]         blank_reg;
    logic [NW-1:0]      count_reg;
    logic               first_reg;
    logic               ovf_reg;
    logic [RW-1:0]      s_reg;
    logic [7:0]         ch_reg;
    logic               chv_reg;
    logic [7:0]         l2_reg;
    logic signed [31:0] a0_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] a2_reg;
    logic signed [31:0] acc_reg;
    logic               done_reg;
    logic [30:0]        loss_reg;
    logic               inf_reg;
    logic               ovo_reg;

    logic signed [31:0] la_x;
    logic signed [31:0] la_y;
    logic signed [31:0] la_z;
    logic signed [31:0] la_b;
    logic [RW-1:0]      n_top;
    logic signed [31:0] pval;
    logic signed [32:0] neg_ll;

    always_ff @(posedge clk)
    begin
        if (prob_we)
            prob_mem[prob_wa] <= prob_wd;
        prob_rd <= prob_mem[prob_ra];
        if (tgt_we)
            tgt_mem[tgt_wa] <= label;
        tgt_rd <= tgt_mem[tgt_ra];
        if (alpha_we)
            alpha_mem[alpha_wa] <= alpha_wd;
        alpha_rd <= alpha_mem[alpha_ra];
    end

    // two-stage logadd chain for the three summands
    ctcfl_logadd #(.FRAC_BITS(FRAC_BITS)) u_la0 (.a(a0_reg), .b(a1_reg), .y(la_x));
    assign la_b = (l2_reg != ch_reg) ? a2_reg : ctcfl_pkg::NEG_INF;
    ctcfl_logadd #(.FRAC_BITS(FRAC_BITS)) u_la1 (.a(acc_reg), .b(la_b), .y(la_y));
    ctcfl_logadd #(.FRAC_BITS(FRAC_BITS)) u_la2 (.a(a0_reg), .b(a1_reg), .y(la_z));

    assign n_top = {count_reg, 1'b0};
    assign pval  = (!chv_reg) ? ctcfl_pkg::NEG_INF : prob_rd;
    assign neg_ll = -{la_z[31], la_z};

    // memory port control
    always_comb
    begin
        prob_we  = 1'b0;
        prob_wa  = label[CW-1:0];
        prob_wd  = (log_prob == 24'sh800000) ? ctcfl_pkg::NEG_INF
                                              : {{8{log_prob[23]}}, log_prob};
        tgt_we   = 1'b0;
        tgt_wa   = count_reg[TW-1:0];
        alpha_we = 1'b0;
        alpha_wa = s_reg;
        alpha_wd = ctcfl_pkg::NEG_INF;
        prob_ra  = ch_reg[CW-1:0];
        tgt_ra   = TW'(s_reg >> 1);
        alpha_ra = s_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && req_type == ctcfl_pkg::REQ_SAMPLE
                    && 32'(label) < NUM_CLASSES)
                    prob_we = 1'b1;
                if (start && req_type == ctcfl_pkg::REQ_LABEL && first_reg
                    && 32'(count_reg) < MAX_TARGET)
                    tgt_we = 1'b1;
                tgt_ra = '0;
            end
            S_INIT_WR:
            begin
                alpha_we = 1'b1;
                alpha_wd = pval;
            end
            S_CLR:
                alpha_we = 1'b1;
            // neighbor reads: s-1 and the label two states back, then s-2
            S_UPD_LAB:
            begin
                alpha_ra = s_reg - 1'b1;
                tgt_ra   = TW'((s_reg >> 1) - 1'b1);
            end
            S_UPD_P:
                alpha_ra = s_reg - RW'(2);
            S_UPD_WR:
            begin
                alpha_we = 1'b1;
                if (s_reg <= n_top)
                    alpha_wd = ((la_y == ctcfl_pkg::NEG_INF) || (pval == ctcfl_pkg::NEG_INF))
                        ? ctcfl_pkg::NEG_INF
                        : ctcfl_pkg::sat32({{2{la_y[31]}}, la_y} + {{2{pval[31]}}, pval});
            end
            default: ;
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            blank_reg <= '0;
            count_reg <= '0;
            first_reg <= 1'b1;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            s_reg     <= '0;
            loss_reg  <= '0;
            inf_reg   <= 1'b0;
            ovo_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                blank_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        case (req_type)
                            ctcfl_pkg::REQ_START:
                            begin
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                                first_reg <= 1'b1;
                            end
                            ctcfl_pkg::REQ_LABEL:
                            begin
                                if (first_reg)
                                begin
                                    if (32'(count_reg) < MAX_TARGET)
                                        count_reg <= count_reg + 1'b1;
                                    else
                                        ovf_reg <= 1'b1;
                                end
                            end
                            ctcfl_pkg::REQ_SAMPLE:
                            begin
                                if (last_in_step)
                                begin
                                    if (first_reg)
                                    begin
                                        s_reg     <= '0;
                                        state_reg <= S_INIT_RD;
                                    end
                                    else
                                    begin
                                        s_reg     <= n_top;
                                        state_reg <= S_UPD_RD;
                                    end
                                end
                            end
                            default:
                            begin
                                s_reg     <= n_top;
                                state_reg <= S_FIN_RD;
                            end
                        endcase
                    end
                end
                // first step: row[0] and row[1], rest of the live row cleared
                S_INIT_RD:
                    state_reg <= S_INIT_P;
                S_INIT_P:
                    state_reg <= S_INIT_WR;
                S_INIT_WR:
                begin
                    if (s_reg == '0 && count_reg != '0)
                    begin
                        s_reg     <= RW'(1);
                        state_reg <= S_INIT_RD;
                    end
                    else
                    begin
                        s_reg     <= (s_reg == '0) ? RW'(1) : RW'(2);
                        state_reg <= S_CLR;
                    end
                    first_reg <= 1'b0;
                end
                S_CLR:
                begin
                    if (s_reg >= n_top)
                        state_reg <= S_IDLE;
                    else
                        s_reg <= s_reg + 1'b1;
                end
                // update walks s downward from 2L, old values below s stay intact
                S_UPD_RD:
                    state_reg <= S_UPD_LAB;
                S_UPD_LAB:
                    state_reg <= S_UPD_P;
                S_UPD_P:
                    state_reg <= S_UPD_A2;
                S_UPD_A2:
                    state_reg <= S_UPD_WR;
                S_UPD_WR:
                begin
                    if (s_reg == '0)
                        state_reg <= S_IDLE;
                    else
                    begin
                        s_reg     <= s_reg - 1'b1;
                        state_reg <= S_UPD_RD;
                    end
                end
                S_FIN_RD:
                begin
                    state_reg <= S_FIN_A;
                    s_reg     <= (count_reg != '0) ? n_top - 1'b1 : s_reg;
                end
                S_FIN_A:
                    state_reg <= S_FIN_B;
                S_FIN_B:
                    state_reg <= S_FIN_OUT;
                S_FIN_OUT:
                begin
                    done_reg  <= 1'b1;
                    ovo_reg   <= ovf_reg;
                    state_reg <= S_IDLE;
                    if (first_reg)
                    begin
                        inf_reg  <= count_reg != '0;
                        loss_reg <= (count_reg != '0) ? 31'h7FFF_FFFF : '0;
                    end
                    else if (la_z == ctcfl_pkg::NEG_INF)
                    begin
                        inf_reg  <= 1'b1;
                        loss_reg <= 31'h7FFF_FFFF;
                    end
                    else
                    begin
                        inf_reg  <= 1'b0;
                        loss_reg <= neg_ll[32] ? '0 : neg_ll[30:0];
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers: labels, neighbor terms and finish operands
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_INIT_RD:
            begin
                if (s_reg == RW'(1))
                begin
                    ch_reg  <= tgt_rd;
                    chv_reg <= 32'(tgt_rd) < NUM_CLASSES;
                end
                else
                begin
                    ch_reg  <= blank_reg;
                    chv_reg <= 32'(blank_reg) < NUM_CLASSES;
                end
            end
            S_UPD_LAB:
            begin
                a0_reg  <= alpha_rd;
                ch_reg  <= s_reg[0] ? tgt_rd : blank_reg;
                chv_reg <= s_reg[0] ? (32'(tgt_rd) < NUM_CLASSES)
                                    : (32'(blank_reg) < NUM_CLASSES);
            end
            S_UPD_P:
            begin
                a1_reg <= (s_reg == '0) ? ctcfl_pkg::NEG_INF : alpha_rd;
                l2_reg <= s_reg[0] ? tgt_rd : blank_reg;
            end
            S_UPD_A2:
            begin
                a2_reg  <= (s_reg < RW'(2)) ? ctcfl_pkg::NEG_INF : alpha_rd;
                acc_reg <= la_x;
            end
            S_FIN_A:
                a0_reg <= alpha_rd;
            S_FIN_B:
                a1_reg <= (count_reg != '0) ? alpha_rd : ctcfl_pkg::NEG_INF;
            default: ;
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign loss            = loss_reg;
    assign loss_infinite   = inf_reg;
    assign target_overflow = ovo_reg;

endmodule

// ===== hdl/ctcfl_check.sv =====
module ctcfl_check (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       done,
    input logic [30:0] loss,
    input logic       loss_infinite
);

    // infinite result always carries the saturated loss
    a_inf_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && loss_infinite |-> loss == 31'h7FFF_FFFF)
        else $error("infinite loss not saturated");

    // no result strobes twice in a row
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("double result");

    // a finish word makes the block busy
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == ctcfl_pkg::REQ_FINISH |=> busy)
        else $error("finish not taken");

endmodule

bind ctc_forward_loss ctcfl_check u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .req_type(req_type), .done(done), .loss(loss),
    .loss_infinite(loss_infinite)
);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS      = 256;
    localparam int MAXT      = 64;
    localparam int ROWN      = 2 * MAXT + 1;
    localparam int WALK_WAIT = 4 * ROWN + 100;
    localparam int LIMIT     = 3000000;

    // log(1+exp(-x)) at half steps, Q.12
    localparam int SOFT_TAB [16] = '{2839, 1942, 1283, 825, 520, 323, 199, 122,
                                     74, 45, 28, 17, 10, 6, 4, 2};

    typedef struct {
        logic [30:0] loss;
        logic        inf;
        logic        ovf;
    } loss_word_t;

    typedef struct {
        ctcfl_pkg::req_t    rq;
        logic [7:0]         lb;
        logic signed [23:0] lp;
        logic               ls;
        bit                 typed;
        logic [30:0]        e_loss;
        logic               e_inf;
        logic               e_ovf;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_data = 8'd0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         req_type = ctcfl_pkg::REQ_START;
    logic [7:0]         label = 8'd0;
    logic signed [23:0] log_prob = 24'sd0;
    logic               last_in_step = 1'b0;
    logic               done;
    logic [30:0]        loss;
    logic               loss_infinite;
    logic               target_overflow;

    // predictor state
    logic [7:0]  blank_cls;
    logic [7:0]  tgt_labels [MAXT];
    int          tgt_len;
    int          alpha [ROWN];
    int          cls_prob [NCLS];
    bit          row_fresh;
    bit          tgt_ovf;

    loss_word_t  loss_q [$];
    dir_row_t    dir_q [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          burst = 1'b0;

    ctc_forward_loss i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .label           (label),
        .log_prob        (log_prob),
        .last_in_step    (last_in_step),
        .done            (done),
        .loss            (loss),
        .loss_infinite   (loss_infinite),
        .target_overflow (target_overflow)
    );

    always #10 clk = ~clk;

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647)
            return 2147483647;
        if (v < -64'sd2147483647)
            return -2147483647;
        return int'(v);
    endfunction

    // log-domain add with table correction
    function automatic int log_sum(input int a, input int b);
        int     hi;
        int     lo;
        longint idx;
        longint corr;
        if (a == ctcfl_pkg::NEG_INF)
            return b;
        if (b == ctcfl_pkg::NEG_INF)
            return a;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        idx = (longint'(hi) - longint'(lo) + 1024) >>> 11;
        corr = (idx < 0 || idx >= 16) ? 0 : SOFT_TAB[idx];
        return clip32(longint'(hi) + corr);
    endfunction

    function automatic int add_prob(input int a, input int p);
        if (a == ctcfl_pkg::NEG_INF || p == ctcfl_pkg::NEG_INF)
            return ctcfl_pkg::NEG_INF;
        return clip32(longint'(a) + longint'(p));
    endfunction

    function automatic logic [7:0] ext_sym(input int s);
        if ((s % 2) == 0)
            return blank_cls;
        return tgt_labels[(s / 2) % MAXT];
    endfunction

    // alpha row update at the end of a time step
    task automatic close_step();
        int         n;
        int         acc;
        logic [7:0] ch;
        n = 2 * tgt_len + 1;
        if (row_fresh)
        begin
            for (int s = 0; s < ROWN; s++)
                alpha[s] = ctcfl_pkg::NEG_INF;
            alpha[0] = cls_prob[blank_cls];
            if (tgt_len > 0)
                alpha[1] = cls_prob[ext_sym(1)];
            row_fresh = 1'b0;
        end
        else
        begin
            for (int s = ROWN - 1; s >= 0; s--)
            begin
                if (s < n)
                begin
                    ch = ext_sym(s);
                    acc = alpha[s];
                    if (s > 0)
                        acc = log_sum(acc, alpha[s - 1]);
                    if (s > 1 && ext_sym(s - 2) != ch)
                        acc = log_sum(acc, alpha[s - 2]);
                    alpha[s] = add_prob(acc, cls_prob[ch]);
                end
                else
                    alpha[s] = ctcfl_pkg::NEG_INF;
            end
        end
    endtask

    // update the predictor with one accepted word
    task automatic ctc_predict(input ctcfl_pkg::req_t rq, input logic [7:0] lb,
                               input logic signed [23:0] lp, input logic ls);
        loss_word_t w;
        int         ll;
        longint     nl;
        case (rq)
            ctcfl_pkg::REQ_START:
            begin
                tgt_len = 0;
                tgt_ovf = 1'b0;
                row_fresh = 1'b1;
            end
            ctcfl_pkg::REQ_LABEL:
            begin
                if (row_fresh)
                begin
                    if (tgt_len < MAXT)
                    begin
                        tgt_labels[tgt_len] = lb;
                        tgt_len++;
                    end
                    else
                        tgt_ovf = 1'b1;
                end
            end
            ctcfl_pkg::REQ_SAMPLE:
            begin
                cls_prob[lb] = (lp == -24'sd8388608) ? ctcfl_pkg::NEG_INF : int'(lp);
                if (ls)
                    close_step();
            end
            default:
            begin
                if (row_fresh)
                begin
                    w.inf = (tgt_len != 0);
                    w.loss = w.inf ? 31'h7FFF_FFFF : 31'd0;
                end
                else
                begin
                    ll = log_sum(alpha[2 * tgt_len],
                                 (tgt_len > 0) ? alpha[2 * tgt_len - 1]
                                               : ctcfl_pkg::NEG_INF);
                    if (ll == ctcfl_pkg::NEG_INF)
                    begin
                        w.inf = 1'b1;
                        w.loss = 31'h7FFF_FFFF;
                    end
                    else
                    begin
                        nl = -longint'(ll);
                        w.inf = 1'b0;
                        w.loss = (nl < 0) ? 31'd0 : nl[30:0];
                    end
                end
                w.ovf = tgt_ovf;
                loss_q.push_back(w);
            end
        endcase
    endtask

    // present one word after a random gap (none in burst mode), return at the accepting edge
    task automatic send_word(input ctcfl_pkg::req_t rq, input logic [7:0] lb,
                             input logic signed [23:0] lp, input logic ls);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rq;
        label <= lb;
        log_prob <= lp;
        last_in_step <= ls;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        ctc_predict(rq, lb, lp, ls);
    endtask

    // hold off until every loss word is back and the row walk is over
    task automatic wait_idle();
        start <= 1'b0;
        while (loss_q.size() != 0)
            @(posedge clk);
        repeat (WALK_WAIT) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_blank(input logic [7:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        blank_cls = v;
    endtask

    task automatic row(input ctcfl_pkg::req_t rq, input logic [7:0] lb,
                       input logic signed [23:0] lp,
                       input logic ls, input bit typed, input logic [30:0] el,
                       input logic ei, input logic eo);
        dir_row_t r;
        r = '{rq, lb, lp, ls, typed, el, ei, eo};
        dir_q.push_back(r);
    endtask

    function automatic logic signed [23:0] draw_lp();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return -24'sd8388608;
        if (r == 1)
            return -24'sd8388607;
        if (r == 2)
            return 24'sd0;
        if (r < 5)
            return -$signed(24'($urandom_range(0, 8388607)));
        return -$signed(24'($urandom_range(0, 30000)));
    endfunction

    // one well-formed sequence with random content and some noise
    task automatic run_sequence();
        int         len;
        int         steps;
        int         extra;
        logic [7:0] labs [$];
        logic [7:0] cls [$];
        logic [7:0] v;
        burst = ($urandom_range(0, 3) == 0);
        send_word(ctcfl_pkg::REQ_START, 8'($urandom()), draw_lp(), 1'($urandom()));
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 67) : $urandom_range(0, 4);
        labs.delete();
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 5))
                0: v = blank_cls;
                1: v = (labs.size() > 0) ? labs[$] : 8'($urandom());
                default: v = 8'($urandom());
            endcase
            labs.push_back(v);
            send_word(ctcfl_pkg::REQ_LABEL, v, draw_lp(), 1'($urandom()));
        end
        steps = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        for (int t = 0; t < steps; t++)
        begin
            // every class read at the step end is written in this step
            cls.delete();
            cls.push_back(blank_cls);
            for (int i = 0; i < labs.size() && i < MAXT; i++)
                cls.push_back(labs[i]);
            extra = $urandom_range(0, 3);
            for (int i = 0; i < extra; i++)
                cls.push_back(8'($urandom()));
            cls.shuffle();
            for (int i = 0; i < cls.size(); i++)
                send_word(ctcfl_pkg::REQ_SAMPLE, cls[i], draw_lp(), i == cls.size() - 1);
            if ($urandom_range(0, 5) == 0)
                send_word(ctcfl_pkg::REQ_LABEL, 8'($urandom()), draw_lp(), 1'b0);
        end
        // open step left hanging at finish
        if ($urandom_range(0, 5) == 0)
            send_word(ctcfl_pkg::REQ_SAMPLE, blank_cls, draw_lp(), 1'b0);
        send_word(ctcfl_pkg::REQ_FINISH, 8'($urandom()), draw_lp(), 1'($urandom()));
        if ($urandom_range(0, 4) == 0)
            send_word(ctcfl_pkg::REQ_FINISH, 8'($urandom()), draw_lp(), 1'($urandom()));
    endtask

    // compare each loss word with the oldest expectation
    always @(negedge clk)
    begin
        loss_word_t w;
        if (rst_n && done)
        begin
            if (loss_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected loss word: loss=%h inf=%b ovf=%b",
                             loss, loss_infinite, target_overflow);
            end
            else
            begin
                w = loss_q.pop_front();
                if (loss !== w.loss || loss_infinite !== w.inf || target_overflow !== w.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("loss mismatch: exp %h/%b/%b got %h/%b/%b",
                                 w.loss, w.inf, w.ovf, loss, loss_infinite,
                                 target_overflow);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t r;
        blank_cls = 8'd0;
        tgt_len = 0;
        row_fresh = 1'b1;
        tgt_ovf = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_blank(8'd0);

        // directed table
        row(ctcfl_pkg::REQ_FINISH, 8'd0, 24'sd0, 1'b0, 1, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_LABEL, 8'd5, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_FINISH, 8'd0, 24'sd0, 1'b0, 1, 31'h7FFF_FFFF, 1'b1, 1'b0);
        row(ctcfl_pkg::REQ_START, 8'd0, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_LABEL, 8'd3, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_LABEL, 8'd3, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd0, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd3, -24'sd8388607, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd255, -24'sd1, 1'b1, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_LABEL, 8'd9, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd0, -24'sd4096, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd3, -24'sd8388608, 1'b1, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_FINISH, 8'd0, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd3, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_FINISH, 8'd0, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_FINISH, 8'd255, -24'sd8388608, 1'b1, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_START, 8'd0, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd0, -24'sd8388608, 1'b1, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_FINISH, 8'd0, 24'sd0, 1'b0, 1, 31'h7FFF_FFFF, 1'b1, 1'b0);
        row(ctcfl_pkg::REQ_START, 8'd0, 24'sd0, 1'b0, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_SAMPLE, 8'd0, 24'sd0, 1'b1, 0, 31'd0, 1'b0, 1'b0);
        row(ctcfl_pkg::REQ_FINISH, 8'd0, 24'sd0, 1'b0, 1, 31'd0, 1'b0, 1'b0);
        foreach (dir_q[i])
        begin
            r = dir_q[i];
            send_word(r.rq, r.lb, r.lp, r.ls);
            if (r.typed)
                loss_q[$] = '{r.e_loss, r.e_inf, r.e_ovf};
        end

        // random phases over several blank settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_blank(8'd255);
                1: set_blank(8'd0);
                default: set_blank(8'($urandom()));
            endcase
            repeat (6)
                run_sequence();
        end

        wait_idle();
        if (mismatches == 0 && loss_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
